[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/wspg_pkg.sv]
// Shared constants of the wheel speed PI controller: command codes, register
// indexes, stall levels and datapath sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wspg_pkg;

  localparam int unsigned FAIL_TICKS_DEF = 100;

  localparam int CMD_W      = 2;
  localparam int VALUE_W    = 16;
  localparam int DRIVE_W    = 9;
  localparam int LEVEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SETPOINT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRIVE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ENABLE   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_DIV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE    = 3'd6;

  // Stall levels.
  localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_ERROR  = 2'd2;

  // Serial datapath sizes: 16x8 products, 24-bit dividends.
  localparam int PROD_W    = 24;
  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = 5;

endpackage

`default_nettype wire

[hw/rtl/wheel_speed_pid_with_stall_guard.sv]
// A control tick with the loop running walks the bit-serial multiply and divide passes
// (error * scale, over the integral divider; integral over scale; error * gain) and the
// sequencing states; every other command goes from START straight to FINISH. The next beat
// is accepted only after the result is written, so the block works on one command at a time.
// A result waiting under out_stall holds the block in FINISH for as long as it waits.
// Reset (rst, synchronous, active high) restores the register defaults and the loop state.
`timescale 1ns / 1ps
`default_nettype none

module wheel_speed_pid_with_stall_guard #(
  parameter int unsigned FAIL_TICKS = wspg_pkg::FAIL_TICKS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Command channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wspg_pkg::CMD_W-1:0]            cmd,
  input  logic signed [wspg_pkg::VALUE_W-1:0]   value,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [wspg_pkg::DRIVE_W-1:0]   drive,
  output logic [wspg_pkg::LEVEL_W-1:0]          stall_level,
  output logic                                  stall_changed,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wspg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wspg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // The idle tick counter only has to reach FAIL_TICKS, where it saturates.
  localparam int IDLE_W = $clog2(FAIL_TICKS + 1);
  localparam logic [IDLE_W-1:0] IDLE_LIMIT = IDLE_W'(FAIL_TICKS);
  localparam int PW = wspg_pkg::PROD_W;
  localparam int SW = wspg_pkg::STEP_W;

  // The sequencer. A running control tick walks every state in order; any other
  // command goes from START straight to FINISH.
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MUL1,
    S_DIV1,
    S_SUM,
    S_CLAMP,
    S_DIV2,
    S_MUL2,
    S_DRIVE,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0] prop_gain;
  logic [7:0] integ_divider;
  logic [7:0] integ_scale;
  logic [7:0] min_drive;
  logic [7:0] warn_limit;
  logic [7:0] error_limit;
  logic       failsafe_on;

  // Loop state.
  logic signed [17:0]       integral;
  logic signed [15:0]       setpoint;
  logic                     pid_enabled;
  logic signed [8:0]        applied_drive;
  logic [7:0]               stall_count;
  logic [1:0]               stall_state;
  logic [IDLE_W-1:0]        idle_ticks;

  // The beat being worked on.
  logic [1:0]               cmd_q;
  logic signed [15:0]       value_q;
  logic                     run_loop;

  // Serial datapath. err_mag is the multiplicand of both products; acc collects
  // a product most significant multiplier bit first; dvd shifts the dividend
  // out and the quotient in, one bit a cycle, against an 8-bit remainder.
  logic                     err_neg;
  logic [15:0]              err_mag;
  logic [7:0]               mplier;
  logic [PW-1:0]            acc;
  logic [PW-1:0]            dvd;
  logic [7:0]               rem;
  logic [7:0]               divisor;
  logic [SW-1:0]            step;
  logic signed [25:0]       int_sum;
  logic                     int_neg;
  logic signed [8:0]        pwm;

  // A divider or scale written as zero acts as one.
  logic [7:0] div_eff;
  logic [7:0] sc_eff;
  assign div_eff = (integ_divider == 8'd0) ? 8'd1 : integ_divider;
  assign sc_eff  = (integ_scale == 8'd0) ? 8'd1 : integ_scale;

  // Speed error of the beat in hand: setpoint minus measured speed.
  logic signed [16:0] err_full;
  logic [16:0]        err_abs;
  assign err_full = {setpoint[15], setpoint} - {value_q[15], value_q};
  assign err_abs  = err_full[16] ? 17'(-err_full) : 17'(err_full);

  // One shift-add step of the multiplier.
  logic [PW-1:0] acc_step;
  assign acc_step = {acc[PW-2:0], 1'b0} + (mplier[7] ? {8'd0, err_mag} : {PW{1'b0}});

  // One restoring step of the divider.
  logic [8:0]    trial;
  logic          fits;
  logic [7:0]    rem_step;
  logic [PW-1:0] dvd_step;
  assign trial    = {rem, dvd[PW-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_step = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
  assign dvd_step = {dvd[PW-2:0], fits};

  logic last_mul;
  logic last_div;
  assign last_mul = step == SW'(wspg_pkg::MUL_STEPS - 1);
  assign last_div = step == SW'(wspg_pkg::DIV_STEPS - 1);

  // Integral step: the quotient takes the sign of the error.
  logic signed [24:0] q_s;
  assign q_s = err_neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

  // The integral clamp is 255 times the scale, formed as scale * 256 - scale.
  logic [15:0]        imax;
  logic signed [25:0] imax_s;
  logic signed [17:0] int_clamped;
  logic [17:0]        int_mag;
  assign imax   = {sc_eff, 8'd0} - {8'd0, sc_eff};
  assign imax_s = {10'd0, imax};

  always_comb begin
    if (int_sum > imax_s) begin
      int_clamped = {2'b00, imax};
    end else if (int_sum < -imax_s) begin
      int_clamped = -$signed({2'b00, imax});
    end else begin
      int_clamped = int_sum[17:0];
    end
    int_mag = int_clamped[17] ? 18'(-int_clamped) : 18'(int_clamped);
  end

  // Drive sum: proportional term, integral over scale (the quotient left in dvd
  // by the second division) and the minimum-drive offset, which follows the sign
  // of the setpoint and vanishes when the setpoint is zero.
  logic signed [24:0] pterm;
  logic signed [8:0]  iterm;
  logic signed [8:0]  offs;
  logic signed [25:0] drv_sum;
  logic signed [8:0]  drv_sat;

  always_comb begin
    pterm = err_neg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
    iterm = int_neg ? -$signed({1'b0, dvd[7:0]}) : $signed({1'b0, dvd[7:0]});
    if (setpoint == 16'sd0) begin
      offs = 9'sd0;
    end else if (setpoint[15]) begin
      offs = -$signed({1'b0, min_drive});
    end else begin
      offs = $signed({1'b0, min_drive});
    end
    drv_sum = {pterm[24], pterm} + {{17{iterm[8]}}, iterm} + {{17{offs[8]}}, offs};
    if (drv_sum > 26'sd255) begin
      drv_sat = 9'sd255;
    end else if (drv_sum < -26'sd255) begin
      drv_sat = -9'sd255;
    end else begin
      drv_sat = drv_sum[8:0];
    end
  end

  // Everything a beat does to the loop state is settled here and written when the
  // sequencer in FINISH finds the output register free.
  logic signed [17:0] n_integral;
  logic signed [15:0] n_setpoint;
  logic               n_pid;
  logic signed [8:0]  n_drive;
  logic [7:0]         n_count;
  logic [1:0]         n_state;
  logic [IDLE_W-1:0]  n_idle;
  logic               n_event;
  logic               loop_reset;
  logic               near_stall;
  logic [8:0]         warn_m1;

  always_comb begin
    n_integral = integral;
    n_setpoint = setpoint;
    n_pid      = pid_enabled;
    n_drive    = applied_drive;
    n_count    = stall_count;
    n_state    = stall_state;
    n_idle     = idle_ticks;
    n_event    = 1'b0;
    loop_reset = 1'b0;
    // A wheel pushed at full drive that barely moves the right way is stalling.
    near_stall = ((value_q < 16'sd5) && (applied_drive == 9'sd255)) ||
                 ((value_q > -16'sd5) && (applied_drive == -9'sd255));
    // One below the warning limit; a zero limit wraps out of reach of the count.
    warn_m1    = {1'b0, warn_limit} - 9'd1;

    unique case (cmd_q)
      wspg_pkg::CMD_TICK: begin
        if (run_loop) begin
          if (near_stall && (stall_count < error_limit)) begin
            n_count = stall_count + 8'd1;
          end else if (stall_count != 8'd0) begin
            n_count = stall_count - 8'd1;
          end
          n_drive = pwm;
          if (({1'b0, n_count} == warn_m1) && (stall_count == warn_limit)) begin
            n_state = wspg_pkg::LVL_NORMAL;
            n_event = 1'b1;
          end else if ((n_count == warn_limit) && ({1'b0, stall_count} == warn_m1)) begin
            n_state = wspg_pkg::LVL_WARN;
            n_event = 1'b1;
          end else if (n_count == error_limit) begin
            n_state    = wspg_pkg::LVL_ERROR;
            n_event    = 1'b1;
            loop_reset = 1'b1;
          end
        end else if (pid_enabled) begin
          // Stall error: no control, the count drains and the level recovers at zero.
          if (stall_count != 8'd0) begin
            n_count = stall_count - 8'd1;
          end
          if (n_count == 8'd0) begin
            n_state = wspg_pkg::LVL_NORMAL;
            n_event = 1'b1;
          end
        end
        // Command timeout, checked after the control step.
        if (idle_ticks < IDLE_LIMIT) begin
          n_idle = idle_ticks + 1'b1;
          if ((n_idle == IDLE_LIMIT) && failsafe_on) begin
            loop_reset = 1'b1;
          end
        end
      end
      wspg_pkg::CMD_SETPOINT: begin
        n_pid      = 1'b1;
        n_setpoint = value_q;
        loop_reset = value_q == 16'sd0;
        n_idle     = '0;
      end
      wspg_pkg::CMD_DRIVE: begin
        n_pid  = 1'b0;
        n_idle = '0;
        if (value_q > 16'sd255) begin
          n_drive = 9'sd255;
        end else if (value_q < -16'sd255) begin
          n_drive = -9'sd255;
        end else begin
          n_drive = value_q[8:0];
        end
      end
      wspg_pkg::CMD_ENABLE: begin
        n_pid      = value_q != 16'sd0;
        loop_reset = value_q == 16'sd0;
      end
    endcase

    if (loop_reset) begin
      n_integral = '0;
      n_setpoint = '0;
      n_drive    = '0;
    end
  end

  // The output register takes a new beat when it is empty or being emptied.
  logic slot_free;
  assign slot_free = !out_valid || !out_stall;

  // Commands are taken one at a time; a finished result may still wait in the
  // output register while the next command is taken and worked on.
  assign in_stall  = state != S_IDLE;
  // Writes are to come only while idle; the block does not enforce this. cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      prop_gain     <= 8'd6;
      integ_divider <= 8'd8;
      integ_scale   <= 8'd32;
      min_drive     <= 8'd25;
      warn_limit    <= 8'd50;
      error_limit   <= 8'd100;
      failsafe_on   <= 1'b0;
      integral      <= '0;
      setpoint      <= '0;
      pid_enabled   <= 1'b1;
      applied_drive <= '0;
      stall_count   <= '0;
      stall_state   <= wspg_pkg::LVL_NORMAL;
      idle_ticks    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          wspg_pkg::REG_PROP_GAIN:   prop_gain     <= cfg_data;
          wspg_pkg::REG_INTEG_DIV:   integ_divider <= cfg_data;
          wspg_pkg::REG_INTEG_SCALE: integ_scale   <= cfg_data;
          wspg_pkg::REG_MIN_DRIVE:   min_drive     <= cfg_data;
          wspg_pkg::REG_WARN_LIMIT:  warn_limit    <= cfg_data;
          wspg_pkg::REG_ERROR_LIMIT: error_limit   <= cfg_data;
          wspg_pkg::REG_FAILSAFE:    failsafe_on   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // A beat leaving while FINISH refills the register is replaced there.
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            value_q <= value;
            state   <= S_START;
          end
        end
        S_START: begin
          // Latch the error and set up error * scale.
          err_neg <= err_full[16];
          err_mag <= err_abs[15:0];
          mplier  <= sc_eff;
          acc     <= '0;
          step    <= '0;
          run_loop <= (cmd_q == wspg_pkg::CMD_TICK) && pid_enabled &&
                      (stall_state != wspg_pkg::LVL_ERROR);
          if ((cmd_q == wspg_pkg::CMD_TICK) && pid_enabled &&
              (stall_state != wspg_pkg::LVL_ERROR)) begin
            state <= S_MUL1;
          end else begin
            state <= S_FINISH;
          end
        end
        S_MUL1: begin
          acc    <= acc_step;
          mplier <= {mplier[6:0], 1'b0};
          if (last_mul) begin
            dvd     <= acc_step;
            rem     <= '0;
            divisor <= div_eff;
            step    <= '0;
            state   <= S_DIV1;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV1: begin
          dvd  <= dvd_step;
          rem  <= rem_step;
          step <= step + 1'b1;
          if (last_div) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          int_sum <= {{8{integral[17]}}, integral} + {q_s[24], q_s};
          state   <= S_CLAMP;
        end
        S_CLAMP: begin
          // Store the clamped integral and set up integral / scale.
          integral <= int_clamped;
          int_neg  <= int_clamped[17];
          dvd      <= {6'd0, int_mag};
          rem      <= '0;
          divisor  <= sc_eff;
          step     <= '0;
          state    <= S_DIV2;
        end
        S_DIV2: begin
          dvd  <= dvd_step;
          rem  <= rem_step;
          if (last_div) begin
            // Set up error * proportional gain; dvd keeps the quotient.
            acc    <= '0;
            mplier <= prop_gain;
            step   <= '0;
            state  <= S_MUL2;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_MUL2: begin
          acc    <= acc_step;
          mplier <= {mplier[6:0], 1'b0};
          step   <= step + 1'b1;
          if (last_mul) begin
            state <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          pwm   <= drv_sat;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            integral      <= n_integral;
            setpoint      <= n_setpoint;
            pid_enabled   <= n_pid;
            applied_drive <= n_drive;
            stall_count   <= n_count;
            stall_state   <= n_state;
            idle_ticks    <= n_idle;
            drive         <= n_drive;
            stall_level   <= n_state;
            stall_changed <= n_event;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/wspg_checker.sv]
// Port-level checks of the wheel speed PI controller, bound to its top level.
// Depends on wspg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wspg_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [wspg_pkg::DRIVE_W-1:0] drive,
  input wire logic [wspg_pkg::LEVEL_W-1:0]        stall_level,
  input wire logic                                stall_changed
);

  // The saturated drive never shows the one out-of-range code.
  `ASSERT_IMP(a_drive_range, clk, rst, out_valid, drive != 9'h100)

  // A taken command keeps the block busy for at least the next cycle.
  `ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // A fresh result only comes out of a command in progress.
  `ASSERT_IMP(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

  // Entering the stall error level resets the loop, so the drive is off.
  `ASSERT_IMP(a_error_drive_off, clk, rst, out_valid && stall_changed && stall_level == wspg_pkg::LVL_ERROR, drive == 9'sd0)

  // A stalled result beat holds.
  `ASSERT_NXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid && $stable(drive))

endmodule

bind wheel_speed_pid_with_stall_guard wspg_checker u_wspg_checker (.*);

`default_nettype wire
